// File: rtl/mmtn_pkg.sv
// Shared constants for the min-max trajectory normalizer: field widths,
// request and status codes, fixed-point format and stream packing.
// No dependencies.
package mmtn_pkg;

    localparam int SB          = 16;
    localparam int NCH         = 6;
    localparam int NPOS        = 3;
    localparam int CH_W        = 3;
    localparam int IDX_W       = 10;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;
    localparam int Q_FRAC      = 14;
    localparam int QB          = Q_FRAC + 1;
    localparam int STEP_W      = $clog2(QB);

    localparam int STORE_DEPTH_DEF = 1024;

    localparam int S_TDATA_W = ((IDX_W + NCH * SB + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NCH * SB + COUNT_OUT_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

endpackage

// File: rtl/mmtn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/minmax_trajectory_normalizer.sv
// Top level of the min-max trajectory normalizer: sample store, running
// extremes, append sequencer and a shared restoring divider for reads.
// Depends on mmtn_pkg and mmtn_ram.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: index, pos, vel
//  m_*       out  m_tvalid/m_tready  tuser: status; tdata: norm x..vz, count
//  cfg_*     in   cfg_wr_en          cfg_wr_data: derive_velocity
//
// Clear, unused request, full store or bad index: from idle to the finish state.
// Append: one channel per cycle through the shared compare unit, then a store write.
// Read: a RAM wait, then per channel a prepare step and the divider steps
// (one divider, 15 quotient bits); a flat channel skips the divider.
// Reset is asynchronous; the store itself is not cleared and needs no sweep.
// A result waits in the output register; s_tready is high only when idle.
module minmax_trajectory_normalizer #(
    parameter int STORE_DEPTH = mmtn_pkg::STORE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] sample_index, [25:10] pos_x, [41:26] pos_y, [57:42] pos_z,
    // [73:58] vel_x, [89:74] vel_y, [105:90] vel_z, rest zero
    input  logic [mmtn_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [mmtn_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] norm_x, [31:16] norm_y, [47:32] norm_z, [63:48] norm_vx,
    // [79:64] norm_vy, [95:80] norm_vz, [106:96] stored_count, rest zero
    output logic [mmtn_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [mmtn_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data
);

    import mmtn_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam int RW     = SB + 1;
    localparam int DW     = SB + 2;
    localparam int MEM_W  = NCH * SB;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPEND = 3'd1;
    localparam logic [2:0] S_APP_WR = 3'd2;
    localparam logic [2:0] S_RD_WT  = 3'd3;
    localparam logic [2:0] S_PREP   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NCH - 1);
    localparam logic [CH_W-1:0] CH_VEL  = CH_W'(NPOS);

    logic [2:0]              state_reg, state_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    derive_reg, derive_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SB-1:0]    max_reg [NCH];
    logic signed [SB-1:0]    max_next [NCH];
    logic signed [SB-1:0]    min_reg [NCH];
    logic signed [SB-1:0]    min_next [NCH];
    logic signed [SB-1:0]    prev_reg [NPOS];
    logic signed [SB-1:0]    prev_next [NPOS];
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic signed [SB-1:0]    pos_reg [NPOS];
    logic signed [SB-1:0]    pos_next [NPOS];
    logic signed [SB-1:0]    vel_reg [NPOS];
    logic signed [SB-1:0]    vel_next [NPOS];
    logic signed [SB-1:0]    smp_reg [NCH];
    logic signed [SB-1:0]    smp_next [NCH];
    logic signed [SB-1:0]    res_reg [NCH];
    logic signed [SB-1:0]    res_next [NCH];
    logic signed [SB-1:0]    out_norm_reg [NCH];
    logic signed [SB-1:0]    out_norm_next [NCH];
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [COUNT_OUT_W-1:0]  out_count_reg, out_count_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [RW-1:0]           range_reg, range_next;
    logic                    neg_reg, neg_next;
    logic [QB-1:0]           q_reg, q_next;

    logic                    ram_we;
    logic                    ram_re;
    logic [MEM_W-1:0]        ram_wdata;
    logic [MEM_W-1:0]        ram_rdata;
    logic [CMP_W-1:0]        in_idx_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_out_ext;

    logic [1:0]              vl;
    logic signed [SB:0]      pdiff;
    logic signed [SB-1:0]    app_val;
    logic signed [SB-1:0]    rd_val;
    logic signed [SB-1:0]    hi_val;
    logic signed [SB-1:0]    lo_val;
    logic signed [DW-1:0]    diff;
    logic signed [RW-1:0]    range_w;
    logic [DW-1:0]           mag;
    logic [DW-1:0]           trial;
    logic                    ge;
    logic [QB-1:0]           q_new;
    logic signed [SB-1:0]    rmag;
    logic signed [SB-1:0]    div_res;
    logic                    accept;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_idx_ext = CMP_W'(s_tdata[IDX_W-1:0]);
    assign cnt_ext    = CMP_W'(count_reg);
    assign cnt_out_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    mmtn_ram #(
        .WIDTH (MEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_idx_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // append datapath, one channel per cycle
    always_comb
    begin
        vl    = 2'(ch_reg - CH_VEL);
        pdiff = {pos_reg[vl][SB-1], pos_reg[vl]} - {prev_reg[vl][SB-1], prev_reg[vl]};
        if (ch_reg < CH_VEL)
        begin
            app_val = pos_reg[ch_reg[1:0]];
        end
        else if (!derive_reg)
        begin
            app_val = vel_reg[vl];
        end
        else if (count_reg == '0)
        begin
            app_val = '0;
        end
        else if (pdiff[SB] != pdiff[SB-1])
        begin
            app_val = pdiff[SB] ? SMIN : SMAX;
        end
        else
        begin
            app_val = pdiff[SB-1:0];
        end
    end

    // divider datapath
    always_comb
    begin
        rd_val  = ram_rdata[ch_reg*SB +: SB];
        hi_val  = max_reg[ch_reg];
        lo_val  = min_reg[ch_reg];
        diff    = {rd_val[SB-1], rd_val, 1'b0}
                  - {{2{hi_val[SB-1]}}, hi_val}
                  - {{2{lo_val[SB-1]}}, lo_val};
        range_w = {hi_val[SB-1], hi_val} - {lo_val[SB-1], lo_val};
        mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
        trial   = (step_reg == '0) ? rem_reg : {rem_reg[DW-2:0], 1'b0};
        ge      = (trial >= {1'b0, range_reg});
        q_new   = {q_reg[QB-2:0], ge};
        rmag    = {{(SB-QB){1'b0}}, q_new};
        div_res = neg_reg ? -rmag : rmag;
        for (int c = 0; c < NCH; c++)
        begin
            ram_wdata[c*SB +: SB] = smp_reg[c];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        step_next       = step_reg;
        derive_next     = cfg_wr_en ? cfg_wr_data : derive_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        rem_next        = rem_reg;
        range_next      = range_reg;
        neg_next        = neg_reg;
        q_next          = q_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        for (int c = 0; c < NCH; c++)
        begin
            max_next[c]      = max_reg[c];
            min_next[c]      = min_reg[c];
            smp_next[c]      = smp_reg[c];
            res_next[c]      = res_reg[c];
            out_norm_next[c] = out_norm_reg[c];
        end
        for (int c = 0; c < NPOS; c++)
        begin
            prev_next[c] = prev_reg[c];
            pos_next[c]  = pos_reg[c];
            vel_next[c]  = vel_reg[c];
        end

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    ch_next     = '0;
                    for (int c = 0; c < NCH; c++)
                    begin
                        res_next[c] = '0;
                    end
                    for (int c = 0; c < NPOS; c++)
                    begin
                        pos_next[c] = s_tdata[IDX_W + c*SB +: SB];
                        vel_next[c] = s_tdata[IDX_W + (NPOS + c)*SB +: SB];
                    end
                    state_next = S_FINISH;
                    case (s_tuser)
                        REQ_CLEAR:
                        begin
                            for (int c = 0; c < NCH; c++)
                            begin
                                max_next[c] = SMIN;
                                min_next[c] = SMAX;
                            end
                            for (int c = 0; c < NPOS; c++)
                            begin
                                prev_next[c] = '0;
                            end
                            count_next = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (cnt_ext >= CMP_W'(STORE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        REQ_READ:
                        begin
                            if (in_idx_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_RD_WT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                smp_next[ch_reg] = app_val;
                if (app_val > max_reg[ch_reg])
                begin
                    max_next[ch_reg] = app_val;
                end
                if (app_val < min_reg[ch_reg])
                begin
                    min_next[ch_reg] = app_val;
                end
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_APP_WR;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            S_APP_WR:
            begin
                ram_we = 1'b1;
                for (int c = 0; c < NPOS; c++)
                begin
                    prev_next[c] = pos_reg[c];
                end
                count_next = count_reg + CNT_W'(1);
                state_next = S_FINISH;
            end
            S_RD_WT:
            begin
                ch_next    = '0;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (range_w[RW-1] || (range_w == '0))
                begin
                    res_next[ch_reg] = '0;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
                else
                begin
                    rem_next   = mag;
                    range_next = range_w;
                    neg_next   = diff[DW-1];
                    q_next     = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, range_reg}) : trial;
                q_next    = q_new;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QB - 1))
                begin
                    res_next[ch_reg] = div_res;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_PREP;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = cnt_out_ext[COUNT_OUT_W-1:0];
                    for (int c = 0; c < NCH; c++)
                    begin
                        out_norm_next[c] = res_reg[c];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            derive_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NCH; c++)
            begin
                max_reg[c] <= SMIN;
                min_reg[c] <= SMAX;
            end
            for (int c = 0; c < NPOS; c++)
            begin
                prev_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            derive_reg    <= derive_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NCH; c++)
            begin
                max_reg[c] <= max_next[c];
                min_reg[c] <= min_next[c];
            end
            for (int c = 0; c < NPOS; c++)
            begin
                prev_reg[c] <= prev_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        step_reg       <= step_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        rem_reg        <= rem_next;
        range_reg      <= range_next;
        neg_reg        <= neg_next;
        q_reg          <= q_next;
        for (int c = 0; c < NCH; c++)
        begin
            smp_reg[c]      <= smp_next[c];
            res_reg[c]      <= res_next[c];
            out_norm_reg[c] <= out_norm_next[c];
        end
        for (int c = 0; c < NPOS; c++)
        begin
            pos_reg[c] <= pos_next[c];
            vel_reg[c] <= vel_next[c];
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int c = 0; c < NCH; c++)
        begin
            m_tdata[c*SB +: SB] = out_norm_reg[c];
        end
        m_tdata[NCH*SB +: COUNT_OUT_W] = out_count_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;

endmodule

// File: rtl/mmtn_checker.sv
// Port-level checks for the min-max trajectory normalizer, bound to the top.
// Depends on mmtn_pkg and minmax_trajectory_normalizer.
module mmtn_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mmtn_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [mmtn_pkg::STATUS_W-1:0]   m_tuser
);

    import mmtn_pkg::*;

    localparam logic signed [SB-1:0] Q_POS = SB'(1 << Q_FRAC);
    localparam logic signed [SB-1:0] Q_NEG = -Q_POS;

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    // normalized fields are zero on any failed request
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[NCH*SB-1:0] == '0))
        else $error("nonzero normalized data with error status");

    // normalized x and vx stay within [-1, 1]
    a_norm_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[SB-1:0]) >= Q_NEG)
            && ($signed(m_tdata[SB-1:0]) <= Q_POS)
            && ($signed(m_tdata[NPOS*SB +: SB]) >= Q_NEG)
            && ($signed(m_tdata[NPOS*SB +: SB]) <= Q_POS))
        else $error("normalized value out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind minmax_trajectory_normalizer mmtn_checker u_mmtn_checker (.*);
